FILE: rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the bounded double-ended queue: action and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dq_pkg;

    // default number of words held
    localparam int DQ_DEPTH  = 16;
    localparam int DQ_WORD_W = 32;

    // requested action of one transaction
    typedef enum logic [1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    // result status code
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } t_dq_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dq_sts;

endpackage

FILE: rtl/dq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_controller
// Sequencer: takes one transaction, waits for the store read to settle and
// hands the result to the output register once that register is free.
// ----------------------------------------------------------------------------
module dq_controller import dq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall,
    input  t_dq_sts i_sts,
    output logic    o_stall,
    output t_dq_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_stall        = 1'b1;
        o_cmd.accept   = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // output slot free, or being emptied this cycle
                if (!i_sts.out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/dq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Circular word store with head index and occupancy count, address wrap
// logic, pending result registers and the output register.
// ----------------------------------------------------------------------------
module dq_datapath import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dq_cmd                     i_cmd,
    output t_dq_sts                     o_sts,
    input  logic [1:0]                  i_action,
    input  logic signed [DQ_WORD_W-1:0] i_push_value,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic signed [DQ_WORD_W-1:0] o_popped_value,
    output logic [1:0]                  o_status,
    output logic                        o_now_empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    // word store
    logic signed [DQ_WORD_W-1:0] r_mem [DEPTH];
    logic signed [DQ_WORD_W-1:0] r_rd_data;

    // queue state
    logic [IW-1:0] r_head;
    logic [IW-1:0] n_head;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] n_occ;

    // pending result of the accepted transaction
    t_status r_res_status;
    t_status n_status;
    logic    r_res_pop_ok;
    logic    n_pop_ok;
    logic    r_res_empty;

    // output register
    logic                        r_out_valid;
    logic signed [DQ_WORD_W-1:0] r_out_value;
    t_status                     r_out_status;
    logic                        r_out_empty;

    // address arithmetic
    logic          w_full;
    logic          w_empty;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_last;
    logic [IW-1:0] w_rear_wr;
    logic [IW-1:0] w_rear_rd;
    logic [IW-1:0] w_head_dec;
    logic [IW-1:0] w_head_inc;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic          w_re;
    logic [IW-1:0] w_raddr;

    assign w_full  = (r_occ == CW'(DEPTH));
    assign w_empty = (r_occ == '0);

    // slot after the rear word and the rear word itself, wrapped once
    assign w_sum     = {1'b0, r_head} + SW'(r_occ);
    assign w_last    = w_sum - SW'(1);
    assign w_rear_wr = (w_sum >= SW'(DEPTH)) ? IW'(w_sum - SW'(DEPTH)) : IW'(w_sum);
    assign w_rear_rd = (w_last >= SW'(DEPTH)) ? IW'(w_last - SW'(DEPTH)) : IW'(w_last);

    // head moves by one in either direction
    assign w_head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);
    assign w_head_inc = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);

    // action decode
    always_comb begin
        n_head   = r_head;
        n_occ    = r_occ;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        w_we     = 1'b0;
        w_waddr  = w_rear_wr;
        w_re     = 1'b0;
        w_raddr  = r_head;
        unique case (t_action'(i_action))
            ACT_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_rear_wr;
                    n_occ   = r_occ + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_head_dec;
                    n_head  = w_head_dec;
                    n_occ   = r_occ + CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re     = 1'b1;
                    w_raddr  = r_head;
                    n_pop_ok = 1'b1;
                    n_head   = w_head_inc;
                    n_occ    = r_occ - CW'(1);
                end
            end
            ACT_POP_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re     = 1'b1;
                    w_raddr  = w_rear_rd;
                    n_pop_ok = 1'b1;
                    n_occ    = r_occ - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_we) begin
            r_mem[w_waddr] <= i_push_value;
        end
        if (i_cmd.accept && w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // head and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else if (i_cmd.accept) begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_status <= n_status;
            r_res_pop_ok <= n_pop_ok;
            r_res_empty  <= (n_occ == '0);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_res_pop_ok) begin
                r_out_value <= r_rd_data;
            end else if (r_res_status == ST_EMPTY) begin
                r_out_value <= '1;
            end else begin
                r_out_value <= '0;
            end
            r_out_status <= r_res_status;
            r_out_empty  <= r_res_empty;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_popped_value  = r_out_value;
    assign o_status        = r_out_status;
    assign o_now_empty     = r_out_empty;

endmodule

FILE: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words, DEPTH words deep.
//
// Input channel: i_valid / o_stall carry one transaction: i_action (push
// rear, push front, pop front, pop rear) and i_push_value. Output channel:
// o_valid / i_stall carry one result per transaction: o_popped_value (the
// word removed, all ones for a pop on empty, zero for a push), o_status
// (ok, pop on empty, push refused because full) and o_now_empty.
// The result is held in the pending result registers and the registered read
// of the word store, then loaded into the output register, where o_valid rises.
// A new transaction is taken only after that load, with o_stall high until then.
// Reset (synchronous, active low) empties the queue and clears o_valid; the
// store contents are not cleared and need no clearing pass.
// While the receiver stalls, the result holds in the output register; one
// further transaction is taken and its result waits until the slot frees,
// with o_stall high in the meantime.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_action,
    input  logic signed [DQ_WORD_W-1:0] i_push_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [DQ_WORD_W-1:0] o_popped_value,
    output logic [1:0]                  o_status,
    output logic                        o_now_empty
);

    t_dq_cmd w_cmd;
    t_dq_sts w_sts;

    // sequencer
    dq_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    // store, pointers and output register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_now_empty    (o_now_empty)
    );

endmodule

FILE: tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench for the bounded double-ended queue. Each accepted
// transaction is applied to a behavioural model of the deque, and the result
// it predicts is queued. Each result the block delivers is compared field by
// field with the oldest prediction. Directed tests cover pops on empty,
// extreme words, filling and refused pushes. Random traffic then swings the
// occupancy between empty and full. It runs under random idling on both
// sides, a long receiver hold-off and a sender pause, and ends with a stretch
// without idling.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH       = DQ_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    // one result of the block
    typedef struct packed {
        logic signed [DQ_WORD_W-1:0] popped;
        t_status                     status;
        logic                        now_empty;
    } t_deque_result;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_action     = ACT_PUSH_REAR;
    logic signed [DQ_WORD_W-1:0] i_push_value = '0;
    logic                        o_valid;
    logic                        i_stall      = 1'b0;
    logic signed [DQ_WORD_W-1:0] o_popped_value;
    logic [1:0]                  o_status;
    logic                        o_now_empty;

    // model contents, front of the deque at index 0
    logic signed [DQ_WORD_W-1:0] model_words[$];
    t_deque_result               pending_results[$];
    t_deque_result               oldest;

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    bit  hold_req    = 1'b0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_now_empty    (o_now_empty)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_double_ended_queue: errors");
            $finish;
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // behaviour of one action on the model deque, giving its result
    function automatic t_deque_result predict_deque_result(input t_action act,
            input logic signed [DQ_WORD_W-1:0] word);
        t_deque_result r;
        r.popped = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH_REAR: begin
                if (model_words.size() >= DEPTH) r.status = ST_FULL;
                else model_words.push_back(word);
            end
            ACT_PUSH_FRONT: begin
                if (model_words.size() >= DEPTH) r.status = ST_FULL;
                else model_words.push_front(word);
            end
            ACT_POP_FRONT: begin
                if (model_words.size() == 0) begin
                    r.status = ST_EMPTY;
                    r.popped = '1;
                end else begin
                    r.popped = model_words.pop_front();
                end
            end
            default: begin
                if (model_words.size() == 0) begin
                    r.status = ST_EMPTY;
                    r.popped = '1;
                end else begin
                    r.popped = model_words.pop_back();
                end
            end
        endcase
        r.now_empty = (model_words.size() == 0);
        return r;
    endfunction

    // offer one transaction, predict on acceptance, then maybe idle
    task automatic send_transaction(input t_action act,
                                    input logic signed [DQ_WORD_W-1:0] word);
        i_valid      <= 1'b1;
        i_action     <= act;
        i_push_value <= word;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_deque_result(act, word));
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // sender pause until every predicted result has come back
    task automatic wait_for_all_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending", o_popped_value, '0);
            end else begin
                oldest = pending_results.pop_front();
                if (o_popped_value !== oldest.popped)
                    report_mismatch("popped_value", o_popped_value, oldest.popped);
                if (o_status !== oldest.status)
                    report_mismatch("status", 32'(o_status), 32'(oldest.status));
                if (o_now_empty !== oldest.now_empty)
                    report_mismatch("now_empty", 32'(o_now_empty), 32'(oldest.now_empty));
            end
        end
    end

    // receiver: long hold-off on request, otherwise random stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // pops on an empty deque from both ends
    task automatic test_empty_pops();
        send_transaction(ACT_POP_FRONT, $urandom);
        send_transaction(ACT_POP_REAR, $urandom);
    endtask

    // extreme words through both ends, head wrapping below zero
    task automatic test_extreme_words();
        send_transaction(ACT_PUSH_REAR, 32'sh8000_0000);
        send_transaction(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        send_transaction(ACT_PUSH_REAR, 32'sh0000_0000);
        send_transaction(ACT_PUSH_FRONT, -32'sd1);
        send_transaction(ACT_POP_FRONT, $urandom);
        send_transaction(ACT_POP_REAR, $urandom);
        send_transaction(ACT_POP_FRONT, $urandom);
        send_transaction(ACT_POP_REAR, $urandom);
        send_transaction(ACT_POP_FRONT, $urandom);
    endtask

    // fill from both ends, then pushes at either end are refused
    task automatic test_fill_and_refuse();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_transaction($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR,
                             $urandom);
        send_transaction(ACT_PUSH_REAR, $urandom);
        send_transaction(ACT_PUSH_FRONT, $urandom);
    endtask

    // random traffic, push share drifting so the deque swings empty to full
    task automatic test_random_traffic(input int n_items);
        int i;
        int push_pct;
        logic signed [DQ_WORD_W-1:0] word;
        t_action act;
        push_pct = 50;
        for (i = 0; i < n_items; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
                act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            else
                act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
            case ($urandom_range(0, 9))
                0:       word = 32'sh8000_0000;
                1:       word = 32'sh7fff_ffff;
                2:       word = -32'sd1;
                default: word = $urandom;
            endcase
            send_transaction(act, word);
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_receiver_hold();
        int i;
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        for (i = 0; i < 24; i++)
            send_transaction(t_action'($urandom_range(0, 3)), $urandom);
        wait_for_all_results();
        tx_idle_on = 1'b1;
    endtask

    // test sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pops();
        test_extreme_words();
        test_fill_and_refuse();
        test_random_traffic(260);
        wait_for_all_results();
        test_receiver_hold();
        test_random_traffic(60);

        // closing stretch without idling
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(80);
        wait_for_all_results();
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_double_ended_queue: clean");
        else
            $display("tb_double_ended_queue: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dq_pkg.sv
rtl/dq_controller.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
